@@ design/mrs_pkg.sv @@
// Package for the missing-sample repair block: transaction types, FSM states
// and fixed constants. No dependencies.
`default_nettype none

package mrs_pkg;

  // Longest run of corrupted samples held before a forced hold flush (1..15)
  localparam int unsigned MAX_RUN     = 9;
  // Significant bits of a valid sample (8..32); above 16 the output width rules
  localparam int unsigned SAMPLE_BITS = 16;
  // Default width of the record sample counter (4..24)
  localparam int unsigned COUNT_BITS  = 16;

  localparam int unsigned SUM_BITS  = 32;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DIV_BITS  = SUM_BITS + FRAC_BITS;
  localparam int unsigned MEAN_BITS = 24;
  localparam int unsigned PEND_BITS = 4;

  typedef struct packed {
    logic signed [16:0] sample_in;
    logic               record_end;
  } in_t;

  typedef struct packed {
    logic [15:0] sample_out;
    logic        was_repaired;
    logic        run_overflow;
    logic        is_final;
    logic [15:0] record_max;
    logic [15:0] record_min;
    logic [23:0] record_mean_q8;
    logic        no_valid_data;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

@@ design/missing_sample_repair_stats.sv @@
// Missing-sample repair with per-record max, min and Q8 mean.
// Depends on mrs_pkg (types, states, constants).
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------
//  in_     | input     | in_valid/in_stall | mrs_pkg::in_t
//  out_    | output    | out_valid/out_stall | mrs_pkg::out_t
//
// A sample is accepted in ST_IDLE and its results are then presented from ST_EMIT
// as the output register frees up; a corrupted sample that only extends a run gives none.
// The last result of a record takes a statistics update in ST_EMIT, DIV_BITS (40) restoring-divider
// steps for the mean in ST_DIV (skipped with no valid sample) and ST_FIN to present it.
// Synchronous active-low reset returns all record state to its initial values.
// A stalled result holds the output register; input is taken whenever the sequencer idles.
`default_nettype none

module missing_sample_repair_stats #(
  parameter int unsigned COUNT_BITS = mrs_pkg::COUNT_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output      logic         in_stall,
  input  wire mrs_pkg::in_t in_data,
  output      logic         out_valid,
  input  wire logic         out_stall,
  output      mrs_pkg::out_t out_data
);

  localparam int unsigned VAL_BITS = (mrs_pkg::SAMPLE_BITS < 16) ? mrs_pkg::SAMPLE_BITS : 16;
  localparam logic [15:0] SMASK    = 16'((33'd1 << VAL_BITS) - 33'd1);
  localparam int unsigned IT_BITS  = $clog2(mrs_pkg::DIV_BITS);
  localparam int unsigned DB       = mrs_pkg::DIV_BITS;
  localparam int unsigned SB       = mrs_pkg::SUM_BITS;
  localparam int unsigned PB       = mrs_pkg::PEND_BITS;

  // record state
  logic [15:0]           last_r, last_nxt;
  logic                  have_r, have_nxt;
  logic [PB-1:0]         pend_r, pend_nxt;
  logic [15:0]           max_r, max_nxt;
  logic [15:0]           min_r, min_nxt;
  logic [SB-1:0]         sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  // current transaction
  mrs_pkg::state_t       state_r, state_nxt;
  logic [15:0]           n_r, n_nxt;
  logic [15:0]           vp_r, vp_nxt;
  logic [PB-1:0]         left_r, left_nxt;
  logic                  hold_r, hold_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  end_r, end_nxt;

  // final result waiting on the divider
  logic [15:0]           fv_r, fv_nxt;
  logic                  frep_r, frep_nxt;
  logic                  fovf_r, fovf_nxt;

  // divider
  logic [DB-1:0]         dq_r, dq_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [IT_BITS-1:0]    it_r, it_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  mrs_pkg::out_t         out_data_r, out_data_nxt;

  // combinational helper signals
  logic                  slot_free;
  logic                  in_take;
  logic                  corrupt;
  logic [15:0]           n_in;
  logic [15:0]           hv;
  logic [15:0]           avg;
  logic [15:0]           v;
  logic                  v_rep;
  logic [SB:0]           sum_add;
  logic [COUNT_BITS:0]   trial;
  logic                  ge;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != mrs_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign corrupt   = in_data.sample_in[16];
  assign n_in      = in_data.sample_in[15:0] & SMASK;
  assign hv        = have_r ? last_r : 16'd0;
  assign avg       = 16'(({1'b0, vp_r} + {1'b0, n_r}) >> 1);

  // value of the next result
  always_comb begin
    if (left_r != '0) begin
      v     = hold_r ? n_r : avg;
      v_rep = 1'b1;
    end else begin
      v     = n_r;
      v_rep = hold_r;
    end
  end

  assign sum_add = {1'b0, sum_r} + {{(SB - 16 + 1){1'b0}}, v};

  // one restoring-division step
  assign trial = {rem_r, dq_r[DB-1]};
  assign ge    = (trial >= {1'b0, cnt_r});

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    have_nxt      = have_r;
    pend_nxt      = pend_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    vp_nxt        = vp_r;
    left_nxt      = left_r;
    hold_nxt      = hold_r;
    ovf_nxt       = ovf_r;
    end_nxt       = end_r;
    fv_nxt        = fv_r;
    frep_nxt      = frep_r;
    fovf_nxt      = fovf_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    it_nxt        = it_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      mrs_pkg::ST_IDLE: begin
        if (in_take) begin
          end_nxt = in_data.record_end;
          if (corrupt) begin
            if (pend_r >= PB'(mrs_pkg::MAX_RUN) || in_data.record_end) begin
              // flush the run plus this sample as holds
              n_nxt     = hv;
              left_nxt  = pend_r;
              hold_nxt  = 1'b1;
              ovf_nxt   = (pend_r >= PB'(mrs_pkg::MAX_RUN));
              pend_nxt  = '0;
              state_nxt = mrs_pkg::ST_EMIT;
            end else begin
              pend_nxt  = pend_r + PB'(1);
            end
          end else begin
            // interpolate the pending run towards n, then n itself
            n_nxt     = n_in;
            vp_nxt    = have_r ? last_r : n_in;
            left_nxt  = pend_r;
            hold_nxt  = 1'b0;
            ovf_nxt   = 1'b0;
            pend_nxt  = '0;
            last_nxt  = n_in;
            have_nxt  = 1'b1;
            state_nxt = mrs_pkg::ST_EMIT;
          end
        end
      end

      mrs_pkg::ST_EMIT: begin
        if (slot_free) begin
          // running statistics
          if (v > max_r) max_nxt = v;
          if (v < min_r) min_nxt = v;
          sum_nxt = sum_add[SB] ? {SB{1'b1}} : sum_add[SB-1:0];
          if (!(&cnt_r)) cnt_nxt = cnt_r + COUNT_BITS'(1);

          if (left_r != '0) begin
            left_nxt      = left_r - PB'(1);
            vp_nxt        = v;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt.sample_out   = v;
            out_data_nxt.was_repaired = v_rep;
            out_data_nxt.run_overflow = ovf_r;
          end else if (end_r) begin
            fv_nxt   = v;
            frep_nxt = v_rep;
            fovf_nxt = ovf_r;
            dq_nxt   = {sum_nxt, {mrs_pkg::FRAC_BITS{1'b0}}};
            rem_nxt  = '0;
            it_nxt   = '0;
            state_nxt = have_r ? mrs_pkg::ST_DIV : mrs_pkg::ST_FIN;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt.sample_out   = v;
            out_data_nxt.was_repaired = v_rep;
            out_data_nxt.run_overflow = ovf_r;
            state_nxt     = mrs_pkg::ST_IDLE;
          end
        end
      end

      mrs_pkg::ST_DIV: begin
        rem_nxt = ge ? COUNT_BITS'(trial - {1'b0, cnt_r}) : trial[COUNT_BITS-1:0];
        dq_nxt  = {dq_r[DB-2:0], ge};
        it_nxt  = it_r + IT_BITS'(1);
        if (it_r == IT_BITS'(DB - 1)) state_nxt = mrs_pkg::ST_FIN;
      end

      mrs_pkg::ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.sample_out   = fv_r;
          out_data_nxt.was_repaired = frep_r;
          out_data_nxt.run_overflow = fovf_r;
          out_data_nxt.is_final     = 1'b1;
          if (have_r) begin
            out_data_nxt.record_max     = max_r;
            out_data_nxt.record_min     = min_r;
            out_data_nxt.record_mean_q8 = (dq_r[DB-1:mrs_pkg::MEAN_BITS] != '0)
                                        ? {mrs_pkg::MEAN_BITS{1'b1}}
                                        : dq_r[mrs_pkg::MEAN_BITS-1:0];
          end else begin
            out_data_nxt.no_valid_data  = 1'b1;
          end
          // record closed: back to initial state
          last_nxt  = '0;
          have_nxt  = 1'b0;
          pend_nxt  = '0;
          max_nxt   = '0;
          min_nxt   = 16'hFFFF;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = mrs_pkg::ST_IDLE;
        end
      end

      default: state_nxt = mrs_pkg::ST_IDLE;
    endcase
  end

  // control and record state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      have_r      <= 1'b0;
      pend_r      <= '0;
      max_r       <= '0;
      min_r       <= 16'hFFFF;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      have_r      <= have_nxt;
      pend_r      <= pend_nxt;
      max_r       <= max_nxt;
      min_r       <= min_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    vp_r       <= vp_nxt;
    left_r     <= left_nxt;
    hold_r     <= hold_nxt;
    ovf_r      <= ovf_nxt;
    end_r      <= end_nxt;
    fv_r       <= fv_nxt;
    frep_r     <= frep_nxt;
    fovf_r     <= fovf_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    it_r       <= it_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ design/mrs_checker.sv @@
// Port-level checker for missing_sample_repair_stats, with its bind.
// Depends on mrs_pkg (transaction types).
`default_nettype none

module mrs_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire mrs_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire mrs_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // statistics only on the final result of a record
  a_stats_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_final |-> out_data.record_max == 16'd0 &&
      out_data.record_min == 16'd0 && out_data.record_mean_q8 == 24'd0 &&
      !out_data.no_valid_data)
    else $error("statistics on a non-final result");

  // overflow holds are always repairs
  a_ovf_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_overflow |-> out_data.was_repaired)
    else $error("overflow flag without repair");

  // an empty record reports zero statistics on a repaired sample
  a_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_valid_data |-> out_data.is_final &&
      out_data.was_repaired && out_data.record_max == 16'd0 &&
      out_data.record_min == 16'd0 && out_data.record_mean_q8 == 24'd0)
    else $error("bad empty-record result");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind missing_sample_repair_stats mrs_checker u_mrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ sim/missing_sample_repair_stats_tb.sv @@
// Self-checking testbench for missing_sample_repair_stats: repair of corrupted
// samples and per-record max/min/Q8 mean, checked against an in-bench predictor.
// Depends on mrs_pkg and the missing_sample_repair_stats RTL.
module missing_sample_repair_stats_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [16:0] MISSING_MARK = 17'h1FFFF;  // -1 in 17-bit two's complement
  localparam logic [15:0] SAMPLE_MAX   = 16'hFFFF;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 64;   // divider plus result path
  localparam int unsigned RANDOM_ITEMS = 110;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  mrs_pkg::in_t   in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  mrs_pkg::out_t  out_data;

  missing_sample_repair_stats u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mrs_pkg::in_t  sample_items[$];      // samples waiting to be driven
  mrs_pkg::out_t expected_results[$];  // cleaned samples still to arrive
  mrs_pkg::out_t step_results[$];      // results of the sample being predicted

  // predictor state
  logic [15:0]                    last_clean;
  bit                             have_prev;
  int unsigned                    pend_cnt;
  logic [15:0]                    run_max;
  logic [15:0]                    run_min;
  logic [31:0]                    run_sum;
  logic [mrs_pkg::COUNT_BITS-1:0] run_count;

  int unsigned n_errors;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_records;
  int unsigned n_repaired;
  int unsigned n_overflow;
  int unsigned n_no_data;
  int unsigned idle_cycles;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_record();
    last_clean = '0;
    have_prev  = 1'b0;
    pend_cnt   = 0;
    run_max    = '0;
    run_min    = SAMPLE_MAX;
    run_sum    = '0;
    run_count  = '0;
  endfunction

  // One cleaned sample: queue it and fold it into the record statistics
  function automatic void log_clean(logic [15:0] v, bit rep, bit ovf);
    mrs_pkg::out_t r;
    r              = '0;
    r.sample_out   = v;
    r.was_repaired = rep;
    r.run_overflow = ovf;
    step_results.push_back(r);
    if (v > run_max) run_max = v;
    if (v < run_min) run_min = v;
    if (run_sum > 32'hFFFF_FFFF - {16'h0000, v}) run_sum = 32'hFFFF_FFFF;
    else run_sum = run_sum + {16'h0000, v};
    if (run_count != '1) run_count = run_count + mrs_pkg::COUNT_BITS'(1);
    n_repaired += rep;
    n_overflow += ovf;
  endfunction

  function automatic void repair_step(mrs_pkg::in_t item);
    logic [15:0]   n;
    logic [15:0]   vp;
    logic [15:0]   hold_v;
    logic [16:0]   pair;
    logic [39:0]   mean_full;
    mrs_pkg::out_t last_r;
    step_results.delete();
    if (item.sample_in[16]) begin
      // corrupted: extend the run, or flush it as holds
      hold_v = have_prev ? last_clean : 16'h0000;
      if (pend_cnt >= mrs_pkg::MAX_RUN) begin
        repeat (pend_cnt + 1) log_clean(hold_v, 1'b1, 1'b1);
        pend_cnt = 0;
      end else if (item.record_end) begin
        repeat (pend_cnt + 1) log_clean(hold_v, 1'b1, 1'b0);
        pend_cnt = 0;
      end else begin
        pend_cnt = pend_cnt + 1;
      end
    end else begin
      // valid: interpolate the pending run towards n, then n itself
      n  = item.sample_in[15:0];
      vp = have_prev ? last_clean : n;
      repeat (pend_cnt) begin
        pair = {1'b0, vp} + {1'b0, n};
        vp   = pair[16:1];
        log_clean(vp, 1'b1, 1'b0);
      end
      pend_cnt = 0;
      log_clean(n, 1'b0, 1'b0);
      last_clean = n;
      have_prev  = 1'b1;
    end

    // statistics ride on the last result of the record
    if (item.record_end && step_results.size() > 0) begin
      last_r          = step_results.pop_back();
      last_r.is_final = 1'b1;
      if (!have_prev || run_count == '0) begin
        last_r.no_valid_data = 1'b1;
        n_no_data++;
      end else begin
        mean_full = {run_sum, 8'h00} / 40'(run_count);
        last_r.record_max     = run_max;
        last_r.record_min     = run_min;
        last_r.record_mean_q8 = (mean_full > 40'hFF_FFFF) ? 24'hFF_FFFF : mean_full[23:0];
      end
      step_results.push_back(last_r);
      n_records++;
      clear_record();
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report(string msg);
    $display("%0t ns  MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h", n_results, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transactions separated by random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      clear_record();
    end else begin
      if (in_valid && !in_stall) begin
        repair_step(in_data);
        n_items++;
      end
      // hold a stalled transaction, otherwise pick the next step
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= sample_items.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(20, 40);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 6);
              gap_left   = $urandom_range(0, 5);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: rotating 16-bit pattern, reloaded on each wrap of a 6-bit counter of clock cycles
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pat  = '0;
  logic [5:0]  stall_tick = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_tick == '0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '0;
          1:       stall_pat = 16'($urandom());
          2:       stall_pat = 16'($urandom()) & 16'($urandom());
          default: stall_pat = (16'($urandom()) | 16'($urandom())) & 16'hFFFE;
        endcase
      end
      out_stall  <= stall_pat[0];
      stall_pat  = {stall_pat[0], stall_pat[15:1]};
      stall_tick = stall_tick + 6'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mrs_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result, sample_out 0x%0h", out_data.sample_out));
        end else begin
          want = expected_results.pop_front();
          check_field("sample_out",     32'(out_data.sample_out),     32'(want.sample_out));
          check_field("was_repaired",   32'(out_data.was_repaired),   32'(want.was_repaired));
          check_field("run_overflow",   32'(out_data.run_overflow),   32'(want.run_overflow));
          check_field("is_final",       32'(out_data.is_final),       32'(want.is_final));
          check_field("record_max",     32'(out_data.record_max),     32'(want.record_max));
          check_field("record_min",     32'(out_data.record_min),     32'(want.record_min));
          check_field("record_mean_q8", 32'(out_data.record_mean_q8),
                      32'(want.record_mean_q8));
          check_field("no_valid_data",  32'(out_data.no_valid_data),  32'(want.no_valid_data));
        end
        n_results++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  function automatic void push_item(logic [16:0] s, bit rec_end);
    mrs_pkg::in_t it;
    it.sample_in  = s;
    it.record_end = rec_end;
    sample_items.push_back(it);
  endfunction

  function automatic logic [16:0] pick_corrupt();
    if ($urandom_range(0, 3) == 0) return {1'b1, 16'($urandom())};
    return MISSING_MARK;
  endfunction

  function automatic logic [16:0] pick_valid();
    case ($urandom_range(0, 19))
      0:       return 17'h00000;
      1:       return {1'b0, SAMPLE_MAX};
      default: return {1'b0, 16'($urandom())};
    endcase
  endfunction

  initial begin
    int unsigned  rec_len;
    int unsigned  pos;
    int unsigned  run_len;
    int unsigned  kind;
    int unsigned  target;
    mrs_pkg::in_t tail;

    n_errors = 0; n_items = 0; n_results = 0; n_records = 0;
    n_repaired = 0; n_overflow = 0; n_no_data = 0; idle_cycles = 0;

    // leading corruption (incl. a non -1 negative), extremes, interpolation,
    // then trailing corruption held at the last valid sample
    push_item(MISSING_MARK, 1'b0);
    push_item(17'h10000, 1'b0);
    push_item(17'h00000, 1'b0);
    push_item({1'b0, SAMPLE_MAX}, 1'b0);
    push_item(MISSING_MARK, 1'b0);
    push_item(MISSING_MARK, 1'b0);
    push_item(17'd100, 1'b0);
    push_item(MISSING_MARK, 1'b1);
    // run overflow with no valid sample, then a lone trailing hold
    repeat (10) push_item(MISSING_MARK, 1'b0);
    push_item(MISSING_MARK, 1'b1);
    // record of one corrupted sample, record of one valid sample
    push_item(MISSING_MARK, 1'b1);
    push_item({1'b0, SAMPLE_MAX}, 1'b1);

    // random records: mostly valid samples with short and long corrupted runs
    target = sample_items.size() + RANDOM_ITEMS;
    while (sample_items.size() < target) begin
      rec_len = $urandom_range(1, 16);
      pos     = 0;
      while (pos < rec_len) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          push_item(pick_valid(), 1'b0);
          pos++;
        end else begin
          run_len = (kind == 9) ? $urandom_range(7, 12) : $urandom_range(1, 3);
          repeat (run_len) push_item(pick_corrupt(), 1'b0);
          pos += run_len;
        end
      end
      tail            = sample_items.pop_back();
      tail.record_end = 1'b1;
      sample_items.push_back(tail);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d samples over %0d records into %0d results.", n_items, n_records, n_results);
    $display("Repaired %0d (%0d held after run overflow); %0d records had no valid sample.",
             n_repaired, n_overflow, n_no_data);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
